FILE: hdl/plsp_pkg.sv
package plsp_pkg;

  localparam int MAX_VERTS_DEF = 8;

  // Coordinate, difference, product and sum widths of the geometry datapath.
  localparam int CW = 24;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int NW = PW;
  localparam int QB = DW + 1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CUT  = 1'b1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

  typedef struct packed {
    logic   command;
    logic   restart;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    logic   split_ok;
    logic   part;
    coord_t vertex_x;
    coord_t vertex_y;
    logic   last_vertex;
  } out_item_t;

  typedef enum logic [1:0] {
    K_LOAD    = 2'd0,
    K_RESTART = 2'd1,
    K_CUT     = 2'd2
  } kind_t;

  // Classified item. For a cut, dx is made non-negative and dy follows its sign.
  typedef struct packed {
    kind_t  kind;
    logic   vcut;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    diff_t  dx;
    diff_t  dy;
  } job_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vert_t;

  function automatic diff_t ext_c(input coord_t v);
    ext_c = {v[CW-1], v};
  endfunction

  function automatic sum_t ext_p(input prod_t v);
    ext_p = {v[PW-1], v};
  endfunction

endpackage

FILE: hdl/polygon_line_split.sv
// Timing: a load passes through the queue and is written to the vertex memory when the
// back end is idle. A cut scans the edges in turn (read, multiply, sum, check, and for a
// hit the scaling units or the divider); after the scan its results are read back and
// registered for output one at a time, at most MAX_VERTS + 4, and held while out_stall.
// Throughput: one load per cycle while the back end is idle; the queue keeps filling
// while a cut runs. Reset: synchronous active-low rst_n empties the queue, the vertex
// count and the output register and returns the sequencer to idle.
module polygon_line_split #(
  parameter int MAX_VERTS = plsp_pkg::MAX_VERTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  plsp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output plsp_pkg::out_item_t out_data
);

  // The front end classifies each transfer and parks it in a two-entry queue.
  // A cut is normalized there so the cut direction always has dx >= 0.
  logic           job_valid;
  logic           job_pop;
  plsp_pkg::job_t job;

  plsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  // The back end holds the vertex memory and runs the edge scan. Each edge is
  // read, multiplied, tested, and if hit resolved through a bit-serial divider
  // or a pair of bit-serial scaling units. Results leave through one output
  // register, so a stalled result never blocks the queue from filling.
  plsp_back #(
    .MAX_VERTS (MAX_VERTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A failed cut produces exactly one result, and it closes the cut.
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.split_ok |-> out_data.last_vertex)
    else $error("failure result not marked last");

  // A failed cut carries zero coordinates and the left piece code.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.split_ok |->
      out_data.vertex_x == '0 && out_data.vertex_y == '0 && !out_data.part)
    else $error("failure result carries data");

  // After a right piece vertex is transferred, the next result is right piece
  // unless the cut just ended.
  a_right_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.part && !out_data.last_vertex ##1 out_valid
      |-> out_data.part)
    else $error("left piece vertex after right piece");

endmodule

FILE: hdl/plsp_front.sv
module plsp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  plsp_pkg::in_item_t in_data,
  output logic               job_valid,
  output plsp_pkg::job_t     job,
  input  logic               job_pop
);

  plsp_pkg::job_t fifo_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  plsp_pkg::job_t cls;
  plsp_pkg::diff_t rdx, rdy;
  logic           push, pop;

  // Classify the incoming item.
  always_comb begin
    rdx = plsp_pkg::ext_c(in_data.end_x) - plsp_pkg::ext_c(in_data.start_x);
    rdy = plsp_pkg::ext_c(in_data.end_y) - plsp_pkg::ext_c(in_data.start_y);
    cls.sx   = in_data.start_x;
    cls.sy   = in_data.start_y;
    cls.ex   = in_data.end_x;
    cls.vcut = (in_data.start_x == in_data.end_x);
    if (rdx < 0) begin
      cls.dx = -rdx;
      cls.dy = -rdy;
    end else begin
      cls.dx = rdx;
      cls.dy = rdy;
    end
    if (in_data.command == plsp_pkg::CMD_CUT) begin
      cls.kind = plsp_pkg::K_CUT;
    end else if (in_data.restart) begin
      cls.kind = plsp_pkg::K_RESTART;
    end else begin
      cls.kind = plsp_pkg::K_LOAD;
    end
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = fifo_r[rp_r];
  assign push      = in_valid && !in_stall;
  assign pop       = job_pop && job_valid;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= cls;
    end
  end

endmodule

FILE: hdl/plsp_frac.sv
module plsp_frac (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  plsp_pkg::diff_t          m,
  input  logic [plsp_pkg::NW-1:0]  num,
  input  logic [plsp_pkg::NW-1:0]  den,
  output logic                     busy,
  output logic signed [plsp_pkg::DW:0] res
);

  localparam int DW  = plsp_pkg::DW;
  localparam int NW  = plsp_pkg::NW;
  localparam int CNW = $clog2(DW + 1);

  logic [DW-1:0]  am_r, am_nxt;
  logic           neg_r, neg_nxt;
  logic [NW-1:0]  num_r, num_nxt;
  logic [NW-1:0]  den_r, den_nxt;
  logic [NW:0]    r_r, r_nxt;
  logic [DW-1:0]  q_r, q_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [NW:0]    r2, r2s, r3, dext;
  logic           ge1, ge2;
  logic [NW+1:0]  twor;
  logic           up;
  logic [DW:0]    mag;

  assign busy = (cnt_r != '0);
  assign dext = {1'b0, den_r};

  // One multiplier bit per cycle, remainder kept below the denominator.
  always_comb begin
    r2  = {r_r[NW-1:0], 1'b0};
    ge1 = (r2 >= dext);
    r2s = ge1 ? (r2 - dext) : r2;
    r3  = am_r[DW-1] ? (r2s + {1'b0, num_r}) : r2s;
    ge2 = am_r[DW-1] && (r3 >= dext);

    am_nxt  = am_r;
    neg_nxt = neg_r;
    num_nxt = num_r;
    den_nxt = den_r;
    r_nxt   = r_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (start) begin
      am_nxt  = (m < 0) ? DW'(-m) : DW'(m);
      neg_nxt = (m < 0);
      num_nxt = num;
      den_nxt = den;
      r_nxt   = '0;
      q_nxt   = '0;
      cnt_nxt = CNW'(DW);
    end else if (busy) begin
      am_nxt  = {am_r[DW-2:0], 1'b0};
      r_nxt   = ge2 ? (r3 - dext) : r3;
      q_nxt   = {q_r[DW-2:0], 1'b0} + DW'(ge1) + DW'(ge2);
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    twor = {r_r, 1'b0};
    up   = neg_r ? (twor > {2'b00, den_r}) : (twor >= {2'b00, den_r});
    mag  = {1'b0, q_r} + (DW + 1)'(up);
    res  = neg_r ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    am_r  <= am_nxt;
    neg_r <= neg_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    r_r   <= r_nxt;
    q_r   <= q_nxt;
  end

endmodule

FILE: hdl/plsp_div.sv
module plsp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  plsp_pkg::sum_t               n,
  input  plsp_pkg::diff_t              d,
  output logic                         busy,
  output logic signed [plsp_pkg::QB:0] res
);

  localparam int SW  = plsp_pkg::SW;
  localparam int DW  = plsp_pkg::DW;
  localparam int QB  = plsp_pkg::QB;
  localparam int RW  = SW + 2;
  localparam int CNW = $clog2(QB + 1);

  logic [RW-1:0]        rem_r, rem_nxt;
  logic [RW-1:0]        dsh_r, dsh_nxt;
  logic [QB-1:0]        q_r, q_nxt;
  logic                 neg_r, neg_nxt;
  logic [CNW-1:0]       cnt_r, cnt_nxt;
  logic signed [RW-1:0] nn;
  logic                 ge;
  logic [QB:0]          mag;

  assign busy = (cnt_r != '0);

  // Rounded n/d (ties up) as floor((2n + d) / 2d); d is positive here.
  always_comb begin
    nn  = $signed({n, 1'b0}) + $signed(RW'(d));
    ge  = (rem_r >= dsh_r);

    rem_nxt = rem_r;
    dsh_nxt = dsh_r;
    q_nxt   = q_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    if (start) begin
      neg_nxt = (nn < 0);
      rem_nxt = (nn < 0) ? RW'(-nn) : RW'(nn);
      dsh_nxt = RW'({d, 1'b0}) << (QB - 1);
      q_nxt   = '0;
      cnt_nxt = CNW'(QB);
    end else if (busy) begin
      rem_nxt = ge ? (rem_r - dsh_r) : rem_r;
      dsh_nxt = dsh_r >> 1;
      q_nxt   = {q_r[QB-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    mag = {1'b0, q_r} + (QB + 1)'(neg_r && (rem_r != '0));
    res = neg_r ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
  end

endmodule

FILE: hdl/plsp_back.sv
module plsp_back #(
  parameter int MAX_VERTS = plsp_pkg::MAX_VERTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  plsp_pkg::job_t      job,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output plsp_pkg::out_item_t out_data
);

  localparam int IW    = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int CNT_W = $clog2(MAX_VERTS + 1);
  localparam int DW    = plsp_pkg::DW;
  localparam int QB    = plsp_pkg::QB;
  localparam int NW    = plsp_pkg::NW;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_RD   = 10'b00_0000_0010,
    S_MUL  = 10'b00_0000_0100,
    S_DEC  = 10'b00_0000_1000,
    S_CHK  = 10'b00_0001_0000,
    S_FRAC = 10'b00_0010_0000,
    S_DIV  = 10'b00_0100_0000,
    S_NEXT = 10'b00_1000_0000,
    S_EREQ = 10'b01_0000_0000,
    S_EPUT = 10'b10_0000_0000
  } state_t;

  typedef enum logic [7:0] {
    P_FAIL = 8'b0000_0001,
    P_L0   = 8'b0000_0010,
    P_LH0  = 8'b0000_0100,
    P_LH1  = 8'b0000_1000,
    P_L3   = 8'b0001_0000,
    P_RH1  = 8'b0010_0000,
    P_RH0  = 8'b0100_0000,
    P_R6   = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    M_GEN = 2'd0,
    M_VE  = 2'd1,
    M_VC  = 2'd2
  } mode_t;

  state_t              state_r, state_nxt;
  phase_t              ph_r, ph_nxt;
  mode_t               mode_r, mode_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [IW-1:0]       h0_r, h0_nxt, h1_r, h1_nxt;
  logic [1:0]          hits_r, hits_nxt;
  plsp_pkg::job_t      cut_r, cut_nxt;
  plsp_pkg::vert_t     vstore_r [MAX_VERTS];
  plsp_pkg::vert_t     rda_r, rdb_r;
  plsp_pkg::prod_t     p0_r, p1_r, p2_r, p3_r;
  plsp_pkg::prod_t     pr0, pr1, pr2, pr3;
  plsp_pkg::sum_t      s_r, t_r, s_nxt, t_nxt;
  plsp_pkg::diff_t     d2x_r, d2y_r, dvd_r, dvd_nxt;
  logic                skip_r, skip_nxt;
  plsp_pkg::coord_t    hx0_r, hy0_r, hx1_r, hy1_r;
  plsp_pkg::coord_t    bx_r, by_r, bx_nxt, by_nxt;
  plsp_pkg::coord_t    rec_x, rec_y;
  logic                rec;
  logic                ovalid_r, ovalid_nxt;
  plsp_pkg::out_item_t out_r, out_nxt;

  logic [IW-1:0]       last_idx, rd_a, rd_b;
  logic                rd_en, wr_en;
  logic [IW-1:0]       wr_a;
  plsp_pkg::vert_t     wr_d;
  logic [CNT_W-1:0]    ncount;
  plsp_pkg::diff_t     ma0, mb0, ma1, mb1, ma2, mb2, ma3, mb3;
  plsp_pkg::diff_t     ax, ay, bx, by, d2x, d2y, lo, hi, xlo, xhi;
  logic                frac_go, div_go, fx_busy, fy_busy, dv_busy;
  logic [NW-1:0]       fnum, fden;
  plsp_pkg::sum_t      dv_n;
  plsp_pkg::diff_t     dv_d;
  logic signed [DW:0]  fx_res, fy_res;
  logic signed [QB:0]  dv_res;
  logic signed [QB:0]  sumx, sumy;
  logic                gen_ok, out_free;

  assign last_idx = IW'(cnt_r - 1'b1);
  assign out_free = !ovalid_r || !out_stall;
  assign out_valid = ovalid_r;
  assign out_data  = out_r;

  // Vertex memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vstore_r[wr_a] <= wr_d;
    end
    if (rd_en) begin
      rda_r <= vstore_r[rd_a];
      rdb_r <= vstore_r[rd_b];
    end
  end

  // Operand selection for the four multipliers of one edge test.
  always_comb begin
    ax  = plsp_pkg::ext_c(rda_r.x);
    ay  = plsp_pkg::ext_c(rda_r.y);
    bx  = plsp_pkg::ext_c(rdb_r.x);
    by  = plsp_pkg::ext_c(rdb_r.y);
    d2x = bx - ax;
    d2y = by - ay;
    lo  = (ay < by) ? ay : by;
    hi  = (ay < by) ? by : ay;
    xlo = (ax < bx) ? ax : bx;
    xhi = (ax < bx) ? bx : ax;
    ma0 = '0; mb0 = '0; ma1 = '0; mb1 = '0;
    ma2 = '0; mb2 = '0; ma3 = '0; mb3 = '0;
    skip_nxt = 1'b0;
    dvd_nxt  = (d2x < 0) ? -d2x : d2x;
    if (cut_r.vcut) begin
      mode_nxt = M_VC;
      skip_nxt = (ax == bx) || (plsp_pkg::ext_c(cut_r.ex) < xlo) ||
                 (plsp_pkg::ext_c(cut_r.ex) > xhi);
      ma0 = (d2x < 0) ? -d2y : d2y;
      mb0 = plsp_pkg::ext_c(cut_r.ex) - ax;
    end else if (ax == bx) begin
      mode_nxt = M_VE;
      ma0 = plsp_pkg::ext_c(cut_r.sy);        mb0 = cut_r.dx;
      ma1 = ax - plsp_pkg::ext_c(cut_r.sx);   mb1 = cut_r.dy;
      ma2 = lo;                               mb2 = cut_r.dx;
      ma3 = hi;                               mb3 = cut_r.dx;
    end else begin
      mode_nxt = M_GEN;
      ma0 = cut_r.dx; mb0 = d2y;
      ma1 = cut_r.dy; mb1 = d2x;
      ma2 = cut_r.dx; mb2 = plsp_pkg::ext_c(cut_r.sy) - ay;
      ma3 = cut_r.dy; mb3 = plsp_pkg::ext_c(cut_r.sx) - ax;
    end
    pr0 = ma0 * mb0;
    pr1 = ma1 * mb1;
    pr2 = ma2 * mb2;
    pr3 = ma3 * mb3;
  end

  always_comb begin
    s_nxt = (mode_r == M_GEN) ? (plsp_pkg::ext_p(p0_r) - plsp_pkg::ext_p(p1_r))
                              : (plsp_pkg::ext_p(p0_r) + plsp_pkg::ext_p(p1_r));
    t_nxt = plsp_pkg::ext_p(p2_r) - plsp_pkg::ext_p(p3_r);
    if (s_r > 0) begin
      gen_ok = (t_r > 0) && (t_r < s_r);
    end else if (s_r < 0) begin
      gen_ok = (t_r < 0) && (t_r > s_r);
    end else begin
      gen_ok = 1'b0;
    end
    fnum = (t_r < 0) ? NW'(-t_r) : NW'(t_r);
    fden = (s_r < 0) ? NW'(-s_r) : NW'(s_r);
    dv_n = (mode_r == M_VE) ? s_r : plsp_pkg::ext_p(p0_r);
    dv_d = (mode_r == M_VE) ? cut_r.dx : dvd_r;
    sumx = $signed((QB + 1)'(bx_r)) + (QB + 1)'(fx_res);
    sumy = $signed((QB + 1)'(by_r)) + (QB + 1)'(fy_res);
  end

  plsp_frac u_frac_x (
    .clk(clk), .rst_n(rst_n), .start(frac_go), .m(d2x_r),
    .num(fnum), .den(fden), .busy(fx_busy), .res(fx_res)
  );

  plsp_frac u_frac_y (
    .clk(clk), .rst_n(rst_n), .start(frac_go), .m(d2y_r),
    .num(fnum), .den(fden), .busy(fy_busy), .res(fy_res)
  );

  plsp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .n(dv_n), .d(dv_d),
    .busy(dv_busy), .res(dv_res)
  );

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    ph_nxt     = ph_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    h0_nxt     = h0_r;
    h1_nxt     = h1_r;
    hits_nxt   = hits_r;
    cut_nxt    = cut_r;
    bx_nxt     = bx_r;
    by_nxt     = by_r;
    ovalid_nxt = ovalid_r && out_stall;
    out_nxt    = out_r;
    job_pop    = 1'b0;
    rd_en      = 1'b0;
    rd_a       = idx_r;
    rd_b       = (idx_r == last_idx) ? '0 : idx_r + 1'b1;
    wr_en      = 1'b0;
    ncount     = (job.kind == plsp_pkg::K_RESTART) ? '0 : cnt_r;
    wr_a       = IW'(ncount);
    wr_d.x     = job.sx;
    wr_d.y     = job.sy;
    frac_go    = 1'b0;
    div_go     = 1'b0;
    rec        = 1'b0;
    rec_x      = sumx[plsp_pkg::CW-1:0];
    rec_y      = sumy[plsp_pkg::CW-1:0];

    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          case (job.kind)
            plsp_pkg::K_LOAD, plsp_pkg::K_RESTART: begin
              if (ncount < CNT_W'(MAX_VERTS)) begin
                wr_en   = 1'b1;
                cnt_nxt = ncount + 1'b1;
              end else begin
                cnt_nxt = ncount;
              end
            end
            plsp_pkg::K_CUT: begin
              cut_nxt  = job;
              idx_nxt  = '0;
              hits_nxt = '0;
              if (cnt_r == '0) begin
                ph_nxt    = P_FAIL;
                state_nxt = S_EREQ;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL:  state_nxt = S_DEC;
      S_DEC:  state_nxt = S_CHK;
      S_CHK: begin
        bx_nxt = rda_r.x;
        by_nxt = rda_r.y;
        case (mode_r)
          M_GEN: begin
            frac_go   = gen_ok;
            state_nxt = gen_ok ? S_FRAC : S_NEXT;
          end
          M_VE: begin
            by_nxt = '0;
            if (s_r < plsp_pkg::ext_p(p2_r) || s_r > plsp_pkg::ext_p(p3_r)) begin
              state_nxt = S_NEXT;
            end else begin
              div_go    = 1'b1;
              state_nxt = S_DIV;
            end
          end
          M_VC: begin
            bx_nxt    = cut_r.ex;
            div_go    = !skip_r;
            state_nxt = skip_r ? S_NEXT : S_DIV;
          end
          default: state_nxt = S_NEXT;
        endcase
      end
      S_FRAC: begin
        if (!fx_busy && !fy_busy) begin
          rec       = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_DIV: begin
        if (!dv_busy) begin
          rec       = 1'b1;
          rec_x     = bx_r;
          rec_y     = plsp_pkg::coord_t'(by_r + plsp_pkg::coord_t'(dv_res));
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (hits_r == 2'd2) begin
          ph_nxt    = P_L0;
          idx_nxt   = '0;
          state_nxt = S_EREQ;
        end else if (idx_r == last_idx) begin
          ph_nxt    = P_FAIL;
          state_nxt = S_EREQ;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_EREQ: begin
        rd_en     = 1'b1;
        state_nxt = S_EPUT;
      end
      S_EPUT: begin
        if (out_free) begin
          ovalid_nxt          = 1'b1;
          out_nxt.split_ok    = 1'b1;
          out_nxt.part        = 1'b0;
          out_nxt.last_vertex = 1'b0;
          out_nxt.vertex_x    = rda_r.x;
          out_nxt.vertex_y    = rda_r.y;
          state_nxt           = S_EREQ;
          case (ph_r)
            P_FAIL: begin
              out_nxt.split_ok    = 1'b0;
              out_nxt.vertex_x    = '0;
              out_nxt.vertex_y    = '0;
              out_nxt.last_vertex = 1'b1;
              state_nxt           = S_IDLE;
            end
            P_L0: begin
              if (idx_r == h0_r) begin
                ph_nxt = P_LH0;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
            P_LH0: begin
              out_nxt.vertex_x = hx0_r;
              out_nxt.vertex_y = hy0_r;
              ph_nxt           = P_LH1;
            end
            P_LH1: begin
              out_nxt.vertex_x = hx1_r;
              out_nxt.vertex_y = hy1_r;
              idx_nxt          = h1_r + 1'b1;
              ph_nxt           = (h1_r == last_idx) ? P_RH1 : P_L3;
            end
            P_L3: begin
              if (idx_r == last_idx) begin
                ph_nxt = P_RH1;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
            P_RH1: begin
              out_nxt.part     = 1'b1;
              out_nxt.vertex_x = hx1_r;
              out_nxt.vertex_y = hy1_r;
              ph_nxt           = P_RH0;
            end
            P_RH0: begin
              out_nxt.part     = 1'b1;
              out_nxt.vertex_x = hx0_r;
              out_nxt.vertex_y = hy0_r;
              idx_nxt          = h0_r + 1'b1;
              ph_nxt           = P_R6;
            end
            P_R6: begin
              out_nxt.part = 1'b1;
              if (idx_r == h1_r) begin
                out_nxt.last_vertex = 1'b1;
                state_nxt           = S_IDLE;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (rec) begin
      hits_nxt = hits_r + 1'b1;
      if (hits_r == 2'd0) begin
        h0_nxt = idx_r;
      end else begin
        h1_nxt = idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ph_r     <= P_FAIL;
      cnt_r    <= '0;
      hits_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ph_r     <= ph_nxt;
      cnt_r    <= cnt_nxt;
      hits_r   <= hits_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    h0_r  <= h0_nxt;
    h1_r  <= h1_nxt;
    cut_r <= cut_nxt;
    bx_r  <= bx_nxt;
    by_r  <= by_nxt;
    out_r <= out_nxt;
    if (state_r == S_MUL) begin
      p0_r   <= pr0;
      p1_r   <= pr1;
      p2_r   <= pr2;
      p3_r   <= pr3;
      mode_r <= mode_nxt;
      skip_r <= skip_nxt;
      d2x_r  <= d2x;
      d2y_r  <= d2y;
      dvd_r  <= dvd_nxt;
    end
    if (state_r == S_DEC) begin
      s_r <= s_nxt;
      t_r <= t_nxt;
    end
    if (rec && hits_r == 2'd0) begin
      hx0_r <= rec_x;
      hy0_r <= rec_y;
    end
    if (rec && hits_r != 2'd0) begin
      hx1_r <= rec_x;
      hy1_r <= rec_y;
    end
  end

endmodule

FILE: tb/sv/polygon_line_split_tb.sv
module polygon_line_split_tb;

  // Models the expected output of the polygon splitter. It keeps its own copy
  // of the vertex store and computes the full vertex list for every cut.
  class split_scoreboard;
    logic signed [23:0] store_x[plsp_pkg::MAX_VERTS_DEF];
    logic signed [23:0] store_y[plsp_pkg::MAX_VERTS_DEF];
    int count;
    plsp_pkg::out_item_t pending[$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    // m * num / den rounded to nearest, with ties going toward plus infinity.
    // Done one multiplier bit at a time so the product never overflows.
    function longint scale_frac(longint m, longint num, longint den);
      longint am, q, r;
      am = (m < 0) ? -m : m;
      q = 0;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        q = q << 1;
        r = r << 1;
        if (r >= den) begin
          r -= den;
          q++;
        end
        if (am[b]) begin
          r += num;
          if (r >= den) begin
            r -= den;
            q++;
          end
        end
      end
      if (m >= 0) begin
        return q + ((2 * r >= den) ? 1 : 0);
      end
      return -(q + ((2 * r > den) ? 1 : 0));
    endfunction

    function longint div_floor(longint n, longint d);
      if (n >= 0) begin
        return n / d;
      end
      return -((-n + d - 1) / d);
    endfunction

    function longint div_round(longint n, longint d);
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      return div_floor(2 * n + d, 2 * d);
    endfunction

    // Intersection of edge a-b with the cut line through s and e.
    function bit edge_hit(longint ax, longint ay, longint bx, longint by,
                          longint sx, longint sy, longint ex, longint ey,
                          output longint hx, output longint hy);
      longint d1x, d1y, d2x, d2y, den, num, lo, hi, yn;
      hx = 0;
      hy = 0;
      if (sx != ex) begin
        if (ax != bx) begin
          d1x = ex - sx;
          d1y = ey - sy;
          d2x = bx - ax;
          d2y = by - ay;
          den = d1x * d2y - d1y * d2x;
          num = d1x * (sy - ay) - d1y * (sx - ax);
          if (den == 0) return 0;
          if (den < 0) begin
            den = -den;
            num = -num;
          end
          if (num <= 0 || num >= den) return 0;
          hx = ax + scale_frac(d2x, num, den);
          hy = ay + scale_frac(d2y, num, den);
          return 1;
        end
        d1x = ex - sx;
        d1y = ey - sy;
        if (d1x < 0) begin
          d1x = -d1x;
          d1y = -d1y;
        end
        yn = sy * d1x + (ax - sx) * d1y;
        lo = (ay < by) ? ay : by;
        hi = (ay < by) ? by : ay;
        if (yn < lo * d1x || yn > hi * d1x) return 0;
        hx = ax;
        hy = div_round(yn, d1x);
        return 1;
      end
      if (ax == bx) return 0;
      lo = (ax < bx) ? ax : bx;
      hi = (ax < bx) ? bx : ax;
      if (ex < lo || ex > hi) return 0;
      hx = ex;
      hy = ay + div_round((by - ay) * (ex - ax), bx - ax);
      return 1;
    endfunction

    function void push_vertex(bit ok, bit part, longint x, longint y);
      plsp_pkg::out_item_t v;
      v.split_ok = ok;
      v.part = part;
      v.vertex_x = x[23:0];
      v.vertex_y = y[23:0];
      v.last_vertex = 1'b0;
      pending.push_back(v);
    endfunction

    // Notes one accepted input transfer and queues what it should produce.
    function void note_input(plsp_pkg::in_item_t it);
      longint hx[2], hy[2], x, y;
      int hidx[2];
      int hits, j;
      if (it.command == plsp_pkg::CMD_LOAD) begin
        if (it.restart) count = 0;
        if (count < plsp_pkg::MAX_VERTS_DEF) begin
          store_x[count] = it.start_x;
          store_y[count] = it.start_y;
          count++;
        end
        return;
      end
      hits = 0;
      for (int i = 0; i < count && hits < 2; i++) begin
        j = (i + 1 < count) ? i + 1 : 0;
        if (edge_hit(store_x[i], store_y[i], store_x[j], store_y[j],
                     it.start_x, it.start_y, it.end_x, it.end_y, x, y)) begin
          hx[hits] = x;
          hy[hits] = y;
          hidx[hits] = i;
          hits++;
        end
      end
      if (hits < 2) begin
        push_vertex(0, 0, 0, 0);
      end else begin
        for (int i = 0; i <= hidx[0]; i++) push_vertex(1, 0, store_x[i], store_y[i]);
        push_vertex(1, 0, hx[0], hy[0]);
        push_vertex(1, 0, hx[1], hy[1]);
        for (int i = hidx[1] + 1; i < count; i++) push_vertex(1, 0, store_x[i], store_y[i]);
        push_vertex(1, 1, hx[1], hy[1]);
        push_vertex(1, 1, hx[0], hy[0]);
        for (int i = hidx[0] + 1; i <= hidx[1]; i++)
          push_vertex(1, 1, store_x[i], store_y[i]);
      end
      pending[$].last_vertex = 1'b1;
    endfunction

    // Compares one accepted result with the oldest expected vertex.
    function void check_result(plsp_pkg::out_item_t got);
      plsp_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.split_ok !== want.split_ok) begin
        $error("split_ok expected %0d got %0d", want.split_ok, got.split_ok);
        errors++;
      end
      if (got.part !== want.part) begin
        $error("part expected %0d got %0d", want.part, got.part);
        errors++;
      end
      if (got.vertex_x !== want.vertex_x) begin
        $error("vertex_x expected %0d got %0d", want.vertex_x, got.vertex_x);
        errors++;
      end
      if (got.vertex_y !== want.vertex_y) begin
        $error("vertex_y expected %0d got %0d", want.vertex_y, got.vertex_y);
        errors++;
      end
      if (got.last_vertex !== want.last_vertex) begin
        $error("last_vertex expected %0d got %0d", want.last_vertex, got.last_vertex);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  plsp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  plsp_pkg::out_item_t out_data;

  // When set, neither side inserts random idle cycles.
  bit steady = 1'b0;
  split_scoreboard board;

  always #1 clk = ~clk;

  polygon_line_split u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Result side: stall at random, and check every transfer that completes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_result(out_data);
      out_stall <= !steady && ($urandom_range(99) < 7);
    end
  end

  // Presents one item and holds it until the block takes the transfer. Random
  // idle cycles go before the item so valid is never dropped mid-transfer.
  task automatic send_item(plsp_pkg::in_item_t it);
    while (!steady && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
  endtask

  task automatic send_load(bit restart, int x, int y);
    plsp_pkg::in_item_t it;
    it = '0;
    it.command = plsp_pkg::CMD_LOAD;
    it.restart = restart;
    it.start_x = plsp_pkg::coord_t'(x);
    it.start_y = plsp_pkg::coord_t'(y);
    it.end_x = plsp_pkg::coord_t'($urandom());
    it.end_y = plsp_pkg::coord_t'($urandom());
    send_item(it);
  endtask

  task automatic send_cut(int sx, int sy, int ex, int ey);
    plsp_pkg::in_item_t it;
    it.command = plsp_pkg::CMD_CUT;
    it.restart = 1'($urandom_range(1));
    it.start_x = plsp_pkg::coord_t'(sx);
    it.start_y = plsp_pkg::coord_t'(sy);
    it.end_x = plsp_pkg::coord_t'(ex);
    it.end_y = plsp_pkg::coord_t'(ey);
    send_item(it);
  endtask

  // Drops valid and waits until every expected result has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Coordinates mostly in a small window so that cuts actually hit, with the
  // occasional full-range value.
  function automatic logic signed [23:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 5) return plsp_pkg::coord_t'($urandom());
    if (r < 8) return (r == 5) ? 24'sh7fffff : 24'sh800000;
    return plsp_pkg::coord_t'($signed($urandom_range(4000)) - 2000);
  endfunction

  initial begin
    int nverts;
    logic signed [23:0] cx;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Cut with nothing loaded must fail.
    send_cut(0, 0, 100, 100);
    // One vertex: the closing edge is degenerate.
    send_load(1, 50, 50);
    send_cut(0, 0, 100, 100);
    // Square, split by a diagonal, a horizontal and a vertical cut, then a zero-length cut and a cut that misses.
    send_load(1, 0, 0);
    send_load(0, 1000, 0);
    send_load(0, 1000, 1000);
    send_load(0, 0, 1000);
    send_cut(-100, 300, 1100, 700);
    send_cut(-5, 500, 5, 500);
    send_cut(400, -50, 400, 77);
    send_cut(400, 5, 400, 5);
    send_cut(-100, 2000, 100, 2000);
    // Extreme corners, overfilled store: the ninth and tenth loads are ignored.
    send_load(1, 24'sh800000, 24'sh800000);
    send_load(0, 24'sh7fffff, 24'sh800000);
    send_load(0, 24'sh7fffff, 24'sh7fffff);
    send_load(0, 24'sh800000, 24'sh7fffff);
    for (int i = 0; i < 6; i++) send_load(0, i * 3, 24'sh7fffff);
    send_cut(24'sh800000, 0, 24'sh7fffff, 1);
    send_cut(24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh7fffff);
    drain();

    // Random polygons, each followed by a few cuts; one long stretch is steady.
    for (int p = 0; p < 33; p++) begin
      steady = (p >= 15 && p < 22);
      nverts = $urandom_range(8, 1);
      if ($urandom_range(9) == 0) nverts = $urandom_range(10, 9);
      for (int v = 0; v < nverts; v++) send_load(v == 0, pick_coord(), pick_coord());
      for (int c = $urandom_range(3, 1); c > 0; c--) begin
        if ($urandom_range(3) == 0) begin
          cx = pick_coord();
          send_cut(cx, pick_coord(), cx, pick_coord());
        end else begin
          send_cut(pick_coord(), pick_coord(), pick_coord(), pick_coord());
        end
      end
      if (p == 30) drain();
    end
    steady = 1'b0;
    drain();
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Worst case is far below this.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
hdl/plsp_pkg.sv
hdl/plsp_front.sv
hdl/plsp_frac.sv
hdl/plsp_div.sv
hdl/plsp_back.sv
hdl/polygon_line_split.sv
tb/sv/polygon_line_split_tb.sv
